### rtl/void_cluster_energy_engine_defines.svh
// ----------------------------------------------------------------------------
// Void and cluster energy engine assertion macros
// Shared property forms for the port checker.
// ----------------------------------------------------------------------------
`ifndef VOID_CLUSTER_ENERGY_ENGINE_DEFINES_SVH
`define VOID_CLUSTER_ENERGY_ENGINE_DEFINES_SVH

// Checks a consequent in the same cycle as its antecedent.
`define VCEE_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("vcee check failed");

// Checks a consequent in the cycle after its antecedent.
`define VCEE_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("vcee check failed");

`endif

### rtl/vcee_pkg.sv
// ----------------------------------------------------------------------------
// Void and cluster energy engine package
// Grid limits, field widths, command encoding and mode codes.
// ----------------------------------------------------------------------------
package vcee_pkg;

    localparam int MAX_WIDTH  = 32;
    localparam int MAX_HEIGHT = 32;
    localparam int MAX_DEPTH  = 4;

    localparam int XW      = 5;
    localparam int YW      = 5;
    localparam int ZW      = 2;
    localparam int DIM_W   = 6;
    localparam int DEPTH_W = 3;
    localparam int KW      = 17;
    localparam int EW      = 32;

    localparam int ADDR_W   = ZW + YW + XW;
    localparam int E_DEPTH  = 1 << ADDR_W;
    localparam int KADDR_W  = YW + XW;
    localparam int SK_DEPTH = 1 << KADDR_W;
    localparam int TK_DEPTH = 1 << ZW;

    typedef enum logic [1:0] {
        MODE_KSPAT = 2'd0,
        MODE_KTEMP = 2'd1,
        MODE_SET   = 2'd2,
        MODE_CLEAR = 2'd3
    } mode_t;

    typedef enum logic [1:0] {
        REG_GRID_WIDTH  = 2'd0,
        REG_GRID_HEIGHT = 2'd1,
        REG_GRID_DEPTH  = 2'd2
    } reg_idx_t;

    typedef enum logic [2:0] {
        CMD_NOP,
        CMD_CLEAR,
        CMD_KSPAT,
        CMD_KTEMP,
        CMD_SETBIT,
        CMD_SPLAT,
        CMD_TEMPO,
        CMD_SCAN
    } cmd_kind_t;

    typedef struct packed {
        cmd_kind_t           kind;
        logic                sub;
        logic                first;
        logic                bitval;
        logic [ADDR_W-1:0]   addr;
        logic [KADDR_W-1:0]  kaddr;
        logic [ZW-1:0]       oz;
        logic [KW-1:0]       kdata;
    } cmd_t;

endpackage

### rtl/vcee_ram.sv
// ----------------------------------------------------------------------------
// Void and cluster energy engine RAM
// Simple dual-port RAM with one write port and a registered read port.
// ----------------------------------------------------------------------------
module vcee_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

### rtl/vcee_ctrl.sv
// ----------------------------------------------------------------------------
// Void and cluster energy engine controller
// Sequences clearing, kernel writes, splats and the extreme scan.
// ----------------------------------------------------------------------------
module vcee_ctrl (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic [vcee_pkg::DIM_W-1:0]   grid_width,
    input  logic [vcee_pkg::DIM_W-1:0]   grid_height,
    input  logic [vcee_pkg::DEPTH_W-1:0] grid_depth,
    input  logic                         in_valid,
    output logic                         in_stall,
    input  logic [1:0]                   mode,
    input  logic [vcee_pkg::XW-1:0]      pos_x,
    input  logic [vcee_pkg::YW-1:0]      pos_y,
    input  logic [vcee_pkg::ZW-1:0]      pos_z,
    input  logic [vcee_pkg::KW-1:0]      kernel_value,
    output logic                         out_valid,
    input  logic                         out_stall,
    output vcee_pkg::cmd_t               cmd,
    output logic                         res_load
);

    typedef enum logic [3:0] {
        ST_CLR, ST_IDLE, ST_SPL, ST_GAP_T, ST_TMP, ST_GAP_S, ST_SCN, ST_DR1, ST_DR2, ST_FIN
    } state_t;

    state_t                          state_reg;
    vcee_pkg::cmd_t                  cmd_reg;
    logic                            out_valid_reg;
    logic [vcee_pkg::ADDR_W-1:0]     clr_reg;
    logic [vcee_pkg::XW-1:0]         sx_reg, tx_reg, ox_reg;
    logic [vcee_pkg::YW-1:0]         sy_reg, ty_reg, oy_reg;
    logic [vcee_pkg::ZW-1:0]         sz_reg, tz_reg, oz_reg;
    logic                            sub_reg;
    logic                            first_reg;

    logic [vcee_pkg::DIM_W-1:0]      w, h, w_m1, h_m1, ox0_full, oy0_full;
    logic [vcee_pkg::DEPTH_W-1:0]    d, d_m1;
    logic [vcee_pkg::XW-1:0]         ox0, ox_inc;
    logic [vcee_pkg::YW-1:0]         oy0, oy_inc;
    logic [vcee_pkg::ZW-1:0]         tz_inc, sz_inc;
    logic                            x_last, y_last, z_last, oz_last;
    logic                            accept, in_grid;

    always_comb
    begin
        w = (grid_width == '0) ? vcee_pkg::DIM_W'(1) :
            ((grid_width > vcee_pkg::DIM_W'(vcee_pkg::MAX_WIDTH)) ?
             vcee_pkg::DIM_W'(vcee_pkg::MAX_WIDTH) : grid_width);
        h = (grid_height == '0) ? vcee_pkg::DIM_W'(1) :
            ((grid_height > vcee_pkg::DIM_W'(vcee_pkg::MAX_HEIGHT)) ?
             vcee_pkg::DIM_W'(vcee_pkg::MAX_HEIGHT) : grid_height);
        d = (grid_depth == '0) ? vcee_pkg::DEPTH_W'(1) :
            ((grid_depth > vcee_pkg::DEPTH_W'(vcee_pkg::MAX_DEPTH)) ?
             vcee_pkg::DEPTH_W'(vcee_pkg::MAX_DEPTH) : grid_depth);
        w_m1     = w - vcee_pkg::DIM_W'(1);
        h_m1     = h - vcee_pkg::DIM_W'(1);
        d_m1     = d - vcee_pkg::DEPTH_W'(1);
        ox0_full = w - {1'b0, sx_reg};
        oy0_full = h - {1'b0, sy_reg};
        ox0      = (sx_reg == '0) ? '0 : ox0_full[vcee_pkg::XW-1:0];
        oy0      = (sy_reg == '0) ? '0 : oy0_full[vcee_pkg::YW-1:0];
        ox_inc   = ({1'b0, ox_reg} == w_m1) ? '0 : ox_reg + vcee_pkg::XW'(1);
        oy_inc   = ({1'b0, oy_reg} == h_m1) ? '0 : oy_reg + vcee_pkg::YW'(1);
        tz_inc   = ({1'b0, tz_reg} == d_m1) ? '0 : tz_reg + vcee_pkg::ZW'(1);
        sz_inc   = ({1'b0, sz_reg} == d_m1) ? '0 : sz_reg + vcee_pkg::ZW'(1);
        x_last   = ({1'b0, tx_reg} == w_m1);
        y_last   = ({1'b0, ty_reg} == h_m1);
        z_last   = ({1'b0, tz_reg} == d_m1);
        oz_last  = ({1'b0, oz_reg} == d_m1);
        accept   = in_valid && (state_reg == ST_IDLE);
        in_grid  = ({1'b0, pos_x} < w) && ({1'b0, pos_y} < h) && ({1'b0, pos_z} < d);
    end

    assign in_stall  = (state_reg != ST_IDLE);
    assign out_valid = out_valid_reg;
    assign cmd       = cmd_reg;
    assign res_load  = (state_reg == ST_FIN) && (!out_valid_reg || !out_stall);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLR;
            cmd_reg       <= '0;
            out_valid_reg <= 1'b0;
            clr_reg       <= '0;
            sx_reg        <= '0;
            sy_reg        <= '0;
            sz_reg        <= '0;
            tx_reg        <= '0;
            ty_reg        <= '0;
            tz_reg        <= '0;
            ox_reg        <= '0;
            oy_reg        <= '0;
            oz_reg        <= '0;
            sub_reg       <= 1'b0;
            first_reg     <= 1'b0;
        end
        else
        begin
            cmd_reg      <= '0;
            cmd_reg.kind <= vcee_pkg::CMD_NOP;
            if (out_valid_reg && !out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                ST_CLR:
                begin
                    cmd_reg.kind <= vcee_pkg::CMD_CLEAR;
                    cmd_reg.addr <= clr_reg;
                    clr_reg      <= clr_reg + vcee_pkg::ADDR_W'(1);
                    if (clr_reg == vcee_pkg::ADDR_W'(vcee_pkg::E_DEPTH - 1))
                    begin
                        state_reg <= ST_IDLE;
                    end
                end
                ST_IDLE:
                begin
                    if (accept)
                    begin
                        sx_reg    <= pos_x;
                        sy_reg    <= pos_y;
                        sz_reg    <= pos_z;
                        sub_reg   <= (mode == vcee_pkg::MODE_CLEAR);
                        tx_reg    <= '0;
                        ty_reg    <= '0;
                        state_reg <= ST_GAP_S;
                        unique case (mode)
                            vcee_pkg::MODE_KSPAT:
                            begin
                                if (({1'b0, pos_x} < vcee_pkg::DIM_W'(vcee_pkg::MAX_WIDTH)) &&
                                    ({1'b0, pos_y} < vcee_pkg::DIM_W'(vcee_pkg::MAX_HEIGHT)))
                                begin
                                    cmd_reg.kind <= vcee_pkg::CMD_KSPAT;
                                end
                                cmd_reg.kaddr <= {pos_y, pos_x};
                                cmd_reg.kdata <= kernel_value;
                            end
                            vcee_pkg::MODE_KTEMP:
                            begin
                                if ({1'b0, pos_z} < vcee_pkg::DEPTH_W'(vcee_pkg::MAX_DEPTH))
                                begin
                                    cmd_reg.kind <= vcee_pkg::CMD_KTEMP;
                                end
                                cmd_reg.oz    <= pos_z;
                                cmd_reg.kdata <= kernel_value;
                            end
                            default:
                            begin
                                if (in_grid)
                                begin
                                    cmd_reg.kind   <= vcee_pkg::CMD_SETBIT;
                                    cmd_reg.addr   <= {pos_z, pos_y, pos_x};
                                    cmd_reg.bitval <= (mode == vcee_pkg::MODE_SET);
                                    state_reg      <= ST_SPL;
                                end
                            end
                        endcase
                    end
                end
                ST_SPL:
                begin
                    if ((tx_reg == '0) && (ty_reg == '0))
                    begin
                        cmd_reg.kaddr <= {oy0, ox0};
                        ox_reg        <= (w == vcee_pkg::DIM_W'(1)) ? '0 :
                                         ((({1'b0, ox0}) == w_m1) ? '0 : ox0 + vcee_pkg::XW'(1));
                        oy_reg        <= oy0;
                    end
                    else
                    begin
                        cmd_reg.kaddr <= {oy_reg, ox_reg};
                        ox_reg        <= ox_inc;
                    end
                    cmd_reg.kind <= vcee_pkg::CMD_SPLAT;
                    cmd_reg.sub  <= sub_reg;
                    cmd_reg.addr <= {sz_reg, ty_reg, tx_reg};
                    if (x_last)
                    begin
                        tx_reg <= '0;
                        ox_reg <= ox0;
                        if ((tx_reg == '0) && (ty_reg == '0))
                        begin
                            oy_reg <= ({1'b0, oy0} == h_m1) ? '0 : oy0 + vcee_pkg::YW'(1);
                        end
                        else
                        begin
                            oy_reg <= oy_inc;
                        end
                        ty_reg <= ty_reg + vcee_pkg::YW'(1);
                        if (y_last)
                        begin
                            ty_reg    <= '0;
                            state_reg <= (d == vcee_pkg::DEPTH_W'(1)) ? ST_GAP_S : ST_GAP_T;
                        end
                    end
                    else
                    begin
                        tx_reg <= tx_reg + vcee_pkg::XW'(1);
                    end
                end
                ST_GAP_T:
                begin
                    tz_reg    <= sz_inc;
                    oz_reg    <= vcee_pkg::ZW'(1);
                    state_reg <= ST_TMP;
                end
                ST_TMP:
                begin
                    cmd_reg.kind <= vcee_pkg::CMD_TEMPO;
                    cmd_reg.sub  <= sub_reg;
                    cmd_reg.addr <= {tz_reg, sy_reg, sx_reg};
                    cmd_reg.oz   <= oz_reg;
                    tz_reg       <= tz_inc;
                    oz_reg       <= oz_reg + vcee_pkg::ZW'(1);
                    if (oz_last)
                    begin
                        state_reg <= ST_GAP_S;
                    end
                end
                ST_GAP_S:
                begin
                    tx_reg    <= '0;
                    ty_reg    <= '0;
                    tz_reg    <= '0;
                    first_reg <= 1'b1;
                    state_reg <= ST_SCN;
                end
                ST_SCN:
                begin
                    cmd_reg.kind  <= vcee_pkg::CMD_SCAN;
                    cmd_reg.first <= first_reg;
                    cmd_reg.addr  <= {tz_reg, ty_reg, tx_reg};
                    first_reg     <= 1'b0;
                    if (x_last)
                    begin
                        tx_reg <= '0;
                        if (y_last)
                        begin
                            ty_reg <= '0;
                            if (z_last)
                            begin
                                state_reg <= ST_DR1;
                            end
                            else
                            begin
                                tz_reg <= tz_reg + vcee_pkg::ZW'(1);
                            end
                        end
                        else
                        begin
                            ty_reg <= ty_reg + vcee_pkg::YW'(1);
                        end
                    end
                    else
                    begin
                        tx_reg <= tx_reg + vcee_pkg::XW'(1);
                    end
                end
                ST_DR1:
                begin
                    state_reg <= ST_DR2;
                end
                ST_DR2:
                begin
                    state_reg <= ST_FIN;
                end
                ST_FIN:
                begin
                    if (!out_valid_reg || !out_stall)
                    begin
                        out_valid_reg <= 1'b1;
                        state_reg     <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

endmodule

### rtl/vcee_datapath.sv
// ----------------------------------------------------------------------------
// Void and cluster energy engine datapath
// Energy, sample and kernel stores, splat update and extreme search.
// ----------------------------------------------------------------------------
module vcee_datapath (
    input  logic                    clk,
    input  logic                    rst_n,
    input  vcee_pkg::cmd_t          cmd,
    input  logic                    res_load,
    output logic                    cluster_found,
    output logic [vcee_pkg::XW-1:0] cluster_x,
    output logic [vcee_pkg::YW-1:0] cluster_y,
    output logic [vcee_pkg::ZW-1:0] cluster_z,
    output logic                    void_found,
    output logic [vcee_pkg::XW-1:0] void_x,
    output logic [vcee_pkg::YW-1:0] void_y,
    output logic [vcee_pkg::ZW-1:0] void_z
);

    vcee_pkg::cmd_t              cmd_d_reg;
    logic [vcee_pkg::KW-1:0]     tk_mem [vcee_pkg::TK_DEPTH];
    logic [vcee_pkg::KW-1:0]     tk_q_reg;
    logic [vcee_pkg::EW-1:0]     e_rd;
    logic [0:0]                  b_rd;
    logic [vcee_pkg::KW-1:0]     k_rd;
    logic [vcee_pkg::KW-1:0]     k_sel;
    logic [vcee_pkg::EW-1:0]     e_new;
    logic                        e_we, b_we;
    logic [vcee_pkg::EW-1:0]     e_wdata;
    logic [0:0]                  b_wdata;

    logic                        cf_reg, vf_reg;
    logic signed [vcee_pkg::EW-1:0] cbest_reg, vbest_reg;
    logic [vcee_pkg::ADDR_W-1:0] cpos_reg, vpos_reg;
    logic                        c_take, v_take, is_scan;

    logic                        cf_out_reg, vf_out_reg;
    logic [vcee_pkg::ADDR_W-1:0] cpos_out_reg, vpos_out_reg;

    always_comb
    begin
        k_sel   = (cmd_d_reg.kind == vcee_pkg::CMD_TEMPO) ? tk_q_reg : k_rd;
        e_new   = cmd_d_reg.sub ? (e_rd - vcee_pkg::EW'(k_sel)) : (e_rd + vcee_pkg::EW'(k_sel));
        e_we    = (cmd_d_reg.kind == vcee_pkg::CMD_SPLAT) ||
                  (cmd_d_reg.kind == vcee_pkg::CMD_TEMPO) ||
                  (cmd_d_reg.kind == vcee_pkg::CMD_CLEAR);
        e_wdata = (cmd_d_reg.kind == vcee_pkg::CMD_CLEAR) ? '0 : e_new;
        b_we    = (cmd_d_reg.kind == vcee_pkg::CMD_SETBIT) ||
                  (cmd_d_reg.kind == vcee_pkg::CMD_CLEAR);
        b_wdata = (cmd_d_reg.kind == vcee_pkg::CMD_SETBIT) ? cmd_d_reg.bitval : 1'b0;
        is_scan = (cmd_d_reg.kind == vcee_pkg::CMD_SCAN);
        c_take  = is_scan && b_rd[0] &&
                  (cmd_d_reg.first || !cf_reg || ($signed(e_rd) > cbest_reg));
        v_take  = is_scan && !b_rd[0] &&
                  (cmd_d_reg.first || !vf_reg || ($signed(e_rd) < vbest_reg));
    end

    vcee_ram #(.WIDTH(vcee_pkg::EW), .DEPTH(vcee_pkg::E_DEPTH)) u_energy (
        .clk   (clk),
        .we    (e_we),
        .waddr (cmd_d_reg.addr),
        .wdata (e_wdata),
        .raddr (cmd.addr),
        .rdata (e_rd)
    );

    vcee_ram #(.WIDTH(1), .DEPTH(vcee_pkg::E_DEPTH)) u_sample (
        .clk   (clk),
        .we    (b_we),
        .waddr (cmd_d_reg.addr),
        .wdata (b_wdata),
        .raddr (cmd.addr),
        .rdata (b_rd)
    );

    vcee_ram #(.WIDTH(vcee_pkg::KW), .DEPTH(vcee_pkg::SK_DEPTH)) u_skernel (
        .clk   (clk),
        .we    (cmd_d_reg.kind == vcee_pkg::CMD_KSPAT),
        .waddr (cmd_d_reg.kaddr),
        .wdata (cmd_d_reg.kdata),
        .raddr (cmd.kaddr),
        .rdata (k_rd)
    );

    always_ff @(posedge clk)
    begin
        if (cmd_d_reg.kind == vcee_pkg::CMD_KTEMP)
        begin
            tk_mem[cmd_d_reg.oz] <= cmd_d_reg.kdata;
        end
        tk_q_reg <= tk_mem[cmd.oz];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cmd_d_reg    <= '0;
            cf_reg       <= 1'b0;
            vf_reg       <= 1'b0;
            cbest_reg    <= '0;
            vbest_reg    <= '0;
            cpos_reg     <= '0;
            vpos_reg     <= '0;
            cf_out_reg   <= 1'b0;
            vf_out_reg   <= 1'b0;
            cpos_out_reg <= '0;
            vpos_out_reg <= '0;
        end
        else
        begin
            cmd_d_reg <= cmd;
            if (is_scan && cmd_d_reg.first)
            begin
                cf_reg   <= 1'b0;
                vf_reg   <= 1'b0;
                cpos_reg <= '0;
                vpos_reg <= '0;
            end
            if (c_take)
            begin
                cf_reg    <= 1'b1;
                cbest_reg <= $signed(e_rd);
                cpos_reg  <= cmd_d_reg.addr;
            end
            if (v_take)
            begin
                vf_reg    <= 1'b1;
                vbest_reg <= $signed(e_rd);
                vpos_reg  <= cmd_d_reg.addr;
            end
            if (res_load)
            begin
                cf_out_reg   <= cf_reg;
                vf_out_reg   <= vf_reg;
                cpos_out_reg <= cf_reg ? cpos_reg : '0;
                vpos_out_reg <= vf_reg ? vpos_reg : '0;
            end
        end
    end

    assign cluster_found = cf_out_reg;
    assign cluster_x     = cpos_out_reg[vcee_pkg::XW-1:0];
    assign cluster_y     = cpos_out_reg[vcee_pkg::XW +: vcee_pkg::YW];
    assign cluster_z     = cpos_out_reg[vcee_pkg::XW + vcee_pkg::YW +: vcee_pkg::ZW];
    assign void_found    = vf_out_reg;
    assign void_x        = vpos_out_reg[vcee_pkg::XW-1:0];
    assign void_y        = vpos_out_reg[vcee_pkg::XW +: vcee_pkg::YW];
    assign void_z        = vpos_out_reg[vcee_pkg::XW + vcee_pkg::YW +: vcee_pkg::ZW];

endmodule

### rtl/void_cluster_energy_engine.sv
// ----------------------------------------------------------------------------
// Void and cluster energy engine
// Toroidal energy store with kernel splats and cluster and void search.
//
//   Channel | Handshake              | Payload
//   --------+------------------------+-------------------------------------
//   cfg     | psel, penable, pwrite  | paddr, pwdata, prdata
//   in      | in_valid, in_stall     | mode, pos_x, pos_y, pos_z, kernel_value
//   out     | out_valid, out_stall   | cluster_*, void_*
//
// A set or clear beat inside the grid runs a splat over its slice, a temporal
// pass over the other slices when D exceeds one, and a scan of all W*H*D cells;
// any other beat runs only the scan. The single read port of the energy RAM
// reads one entry per cycle. After reset a clearing pass over all 4096 entries
// zeroes the energy and sample stores, with in_stall held high.
// A finished result waits in the output register while out_stall is high.
// ----------------------------------------------------------------------------
module void_cluster_energy_engine (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    psel,
    input  logic                    penable,
    input  logic                    pwrite,
    input  logic [3:0]              paddr,
    input  logic [31:0]             pwdata,
    output logic [31:0]             prdata,
    output logic                    pready,
    input  logic                    in_valid,
    output logic                    in_stall,
    input  logic [1:0]              mode,
    input  logic [vcee_pkg::XW-1:0] pos_x,
    input  logic [vcee_pkg::YW-1:0] pos_y,
    input  logic [vcee_pkg::ZW-1:0] pos_z,
    input  logic [vcee_pkg::KW-1:0] kernel_value,
    output logic                    out_valid,
    input  logic                    out_stall,
    output logic                    cluster_found,
    output logic [vcee_pkg::XW-1:0] cluster_x,
    output logic [vcee_pkg::YW-1:0] cluster_y,
    output logic [vcee_pkg::ZW-1:0] cluster_z,
    output logic                    void_found,
    output logic [vcee_pkg::XW-1:0] void_x,
    output logic [vcee_pkg::YW-1:0] void_y,
    output logic [vcee_pkg::ZW-1:0] void_z
);

    logic [vcee_pkg::DIM_W-1:0]   width_reg, height_reg;
    logic [vcee_pkg::DEPTH_W-1:0] depth_reg;
    vcee_pkg::cmd_t               cmd;
    logic                         res_load;
    logic                         wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= vcee_pkg::DIM_W'(32);
            height_reg <= vcee_pkg::DIM_W'(32);
            depth_reg  <= vcee_pkg::DEPTH_W'(1);
        end
        else if (wr_en)
        begin
            unique case (paddr[3:2])
                vcee_pkg::REG_GRID_WIDTH:  width_reg  <= pwdata[vcee_pkg::DIM_W-1:0];
                vcee_pkg::REG_GRID_HEIGHT: height_reg <= pwdata[vcee_pkg::DIM_W-1:0];
                vcee_pkg::REG_GRID_DEPTH:  depth_reg  <= pwdata[vcee_pkg::DEPTH_W-1:0];
                default:
                begin
                end
            endcase
        end
    end

    always_comb
    begin
        unique case (paddr[3:2])
            vcee_pkg::REG_GRID_WIDTH:  prdata = 32'(width_reg);
            vcee_pkg::REG_GRID_HEIGHT: prdata = 32'(height_reg);
            vcee_pkg::REG_GRID_DEPTH:  prdata = 32'(depth_reg);
            default:                   prdata = '0;
        endcase
    end

    vcee_ctrl u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .grid_width   (width_reg),
        .grid_height  (height_reg),
        .grid_depth   (depth_reg),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .mode         (mode),
        .pos_x        (pos_x),
        .pos_y        (pos_y),
        .pos_z        (pos_z),
        .kernel_value (kernel_value),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .cmd          (cmd),
        .res_load     (res_load)
    );

    vcee_datapath u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .res_load      (res_load),
        .cluster_found (cluster_found),
        .cluster_x     (cluster_x),
        .cluster_y     (cluster_y),
        .cluster_z     (cluster_z),
        .void_found    (void_found),
        .void_x        (void_x),
        .void_y        (void_y),
        .void_z        (void_z)
    );

endmodule

### rtl/vcee_checker.sv
// ----------------------------------------------------------------------------
// Void and cluster energy engine port checker
// Watches the top-level ports for handshake and result consistency.
// ----------------------------------------------------------------------------
`include "void_cluster_energy_engine_defines.svh"

module vcee_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       in_valid,
    input logic       in_stall,
    input logic       out_valid,
    input logic       out_stall,
    input logic       cluster_found,
    input logic [4:0] cluster_x,
    input logic [4:0] cluster_y,
    input logic [1:0] cluster_z,
    input logic       void_found,
    input logic [4:0] void_x,
    input logic [4:0] void_y,
    input logic [1:0] void_z
);

    logic cpos_zero;
    logic vpos_zero;

    assign cpos_zero = (cluster_x == 5'd0) && (cluster_y == 5'd0) && (cluster_z == 2'd0);
    assign vpos_zero = (void_x == 5'd0) && (void_y == 5'd0) && (void_z == 2'd0);

    `VCEE_ASSERT_NEXT(a_busy_after_beat, in_valid && !in_stall, in_stall)
    `VCEE_ASSERT_NEXT(a_out_holds, out_valid && out_stall, out_valid)
    `VCEE_ASSERT_NOW(a_some_found, out_valid, cluster_found || void_found)
    `VCEE_ASSERT_NOW(a_no_cluster_zero, out_valid && !cluster_found, cpos_zero)
    `VCEE_ASSERT_NOW(a_no_void_zero, out_valid && !void_found, vpos_zero)

endmodule

bind void_cluster_energy_engine vcee_checker u_vcee_checker (.*);

### tb/tb_void_cluster_energy_engine.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Void and cluster energy engine testbench
// Loads the kernel tables, drives set, clear and kernel-write beats under
// several grid settings, and checks each cluster and void result against
// a predictor of the energy store kept in a small scoreboard class.
// ----------------------------------------------------------------------------
module tb_void_cluster_energy_engine;

    typedef struct packed {
        logic       cf;
        logic [4:0] cx;
        logic [4:0] cy;
        logic [1:0] cz;
        logic       vf;
        logic [4:0] vx;
        logic [4:0] vy;
        logic [1:0] vz;
    } search_t;

    class energy_scoreboard;
        logic [16:0] skern [32][32];
        logic [16:0] tkern [4];
        bit          samp [4][32][32];
        logic [31:0] energy [4][32][32];
        logic [5:0]  reg_w;
        logic [5:0]  reg_h;
        logic [2:0]  reg_d;
        search_t     expected_q[$];
        int          mismatches;

        function new();
            reg_w = 32;
            reg_h = 32;
            reg_d = 1;
            mismatches = 0;
            foreach (energy[z, y, x])
            begin
                energy[z][y][x] = 0;
                samp[z][y][x] = 0;
            end
        endfunction

        function void write_reg(vcee_pkg::reg_idx_t idx, logic [31:0] val);
            case (idx)
                vcee_pkg::REG_GRID_WIDTH:  reg_w = val[5:0];
                vcee_pkg::REG_GRID_HEIGHT: reg_h = val[5:0];
                default:                   reg_d = val[2:0];
            endcase
        endfunction

        function int clampv(int v, int maxv);
            if (v < 1)
                return 1;
            return (v > maxv) ? maxv : v;
        endfunction

        function void note_item(vcee_pkg::mode_t m, int px, int py, int pz, logic [16:0] kv);
            int w, h, d, tz;
            logic [16:0] k;
            logic signed [31:0] e, cbest, vbest;
            search_t r;
            w = clampv(reg_w, vcee_pkg::MAX_WIDTH);
            h = clampv(reg_h, vcee_pkg::MAX_HEIGHT);
            d = clampv(reg_d, vcee_pkg::MAX_DEPTH);
            r = '0;
            cbest = 0;
            vbest = 0;
            if (m == vcee_pkg::MODE_KSPAT)
                skern[py][px] = kv;
            else if (m == vcee_pkg::MODE_KTEMP)
                tkern[pz] = kv;
            else if (px < w && py < h && pz < d)
            begin
                samp[pz][py][px] = (m == vcee_pkg::MODE_SET);
                for (int ty = 0; ty < h; ty++)
                    for (int tx = 0; tx < w; tx++)
                    begin
                        k = skern[(ty + h - py) % h][(tx + w - px) % w];
                        if (m == vcee_pkg::MODE_SET)
                            energy[pz][ty][tx] += k;
                        else
                            energy[pz][ty][tx] -= k;
                    end
                for (int oz = 1; oz < d; oz++)
                begin
                    tz = (pz + oz) % d;
                    if (m == vcee_pkg::MODE_SET)
                        energy[tz][py][px] += tkern[oz];
                    else
                        energy[tz][py][px] -= tkern[oz];
                end
            end
            for (int z = 0; z < d; z++)
                for (int y = 0; y < h; y++)
                    for (int x = 0; x < w; x++)
                    begin
                        e = energy[z][y][x];
                        if (samp[z][y][x])
                        begin
                            if (!r.cf || e > cbest)
                            begin
                                r.cf = 1; cbest = e;
                                r.cx = 5'(x); r.cy = 5'(y); r.cz = 2'(z);
                            end
                        end
                        else if (!r.vf || e < vbest)
                        begin
                            r.vf = 1; vbest = e;
                            r.vx = 5'(x); r.vy = 5'(y); r.vz = 2'(z);
                        end
                    end
            expected_q.push_back(r);
        endfunction

        function void check_result(search_t got);
            search_t want;
            if (expected_q.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("Unexpected result beat: %h", got);
                return;
            end
            want = expected_q.pop_front();
            if (got !== want)
            begin
                mismatches++;
                if (mismatches <= 10)
                begin
                    $display("Mismatch: expected c=%0d (%0d,%0d,%0d) v=%0d (%0d,%0d,%0d)",
                             want.cf, want.cx, want.cy, want.cz,
                             want.vf, want.vx, want.vy, want.vz);
                    $display("          got      c=%0d (%0d,%0d,%0d) v=%0d (%0d,%0d,%0d)",
                             got.cf, got.cx, got.cy, got.cz,
                             got.vf, got.vx, got.vy, got.vz);
                end
            end
        endfunction
    endclass

    logic        clk;
    logic        rst_n;
    logic        psel, penable, pwrite;
    logic [3:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;
    logic        in_valid;
    logic        in_stall;
    logic [1:0]  mode;
    logic [4:0]  pos_x, pos_y;
    logic [1:0]  pos_z;
    logic [16:0] kernel_value;
    logic        out_valid;
    logic        out_stall;
    logic        cluster_found, void_found;
    logic [4:0]  cluster_x, cluster_y, void_x, void_y;
    logic [1:0]  cluster_z, void_z;

    energy_scoreboard sb;
    int burst_left;

    void_cluster_energy_engine u_top (.*);

    always
    begin
        clk = 1'b0;
        #4;
        clk = 1'b1;
        #4;
    end

    initial
    begin
        #40_000_000;
        $display("TEST FAILED");
        $finish;
    end

    // The receiver switches between free flow, random stalls and long stalls.
    initial
    begin
        int phase;
        out_stall = 1'b0;
        forever
        begin
            phase = $urandom_range(0, 2);
            repeat ($urandom_range(16, 96))
            begin
                @(negedge clk);
                case (phase)
                    0: out_stall = 1'b0;
                    1: out_stall = $urandom_range(0, 1);
                    default: out_stall = ($urandom_range(0, 9) != 0);
                endcase
            end
        end
    end

    always @(posedge clk)
        if (rst_n && out_valid && !out_stall)
            sb.check_result({cluster_found, cluster_x, cluster_y, cluster_z,
                             void_found, void_x, void_y, void_z});

    task automatic apb_write(vcee_pkg::reg_idx_t idx, logic [31:0] val);
        @(negedge clk);
        psel = 1'b1;
        pwrite = 1'b1;
        penable = 1'b0;
        paddr = 4'(idx) << 2;
        pwdata = val;
        @(negedge clk);
        penable = 1'b1;
        @(negedge clk);
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        sb.write_reg(idx, val);
    endtask

    task automatic drain;
        while (sb.expected_q.size() != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);
    endtask

    task automatic set_grid(int w, int h, int d);
        drain();
        apb_write(vcee_pkg::REG_GRID_WIDTH, w);
        apb_write(vcee_pkg::REG_GRID_HEIGHT, h);
        apb_write(vcee_pkg::REG_GRID_DEPTH, d);
    endtask

    task automatic send_beat(vcee_pkg::mode_t m, int x, int y, int z, int k);
        @(negedge clk);
        if (burst_left == 0)
        begin
            in_valid = 1'b0;
            repeat ($urandom_range(0, 6)) @(negedge clk);
            burst_left = $urandom_range(1, 8);
        end
        burst_left--;
        in_valid = 1'b1;
        mode = m;
        pos_x = 5'(x);
        pos_y = 5'(y);
        pos_z = 2'(z);
        kernel_value = 17'(k);
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        sb.note_item(m, x, y, z, 17'(k));
    endtask

    task automatic idle_input;
        @(negedge clk);
        in_valid = 1'b0;
    endtask

    task automatic random_phase(int n);
        int w, h, d, r;
        w = $urandom_range(1, 6);
        h = $urandom_range(1, 6);
        d = $urandom_range(1, 4);
        set_grid(w, h, d);
        for (int i = 0; i < n; i++)
        begin
            r = $urandom_range(0, 19);
            if (r < 2)
                send_beat(vcee_pkg::MODE_KSPAT, $urandom_range(0, 31), $urandom_range(0, 31),
                          0, $urandom_range(0, 131071));
            else if (r < 3)
                send_beat(vcee_pkg::MODE_KTEMP, 0, 0, $urandom_range(0, 3),
                          $urandom_range(0, 131071));
            else if (r < 5)
                send_beat(vcee_pkg::mode_t'($urandom_range(2, 3)), $urandom_range(0, 31),
                          $urandom_range(0, 31), $urandom_range(0, 3),
                          $urandom_range(0, 131071));
            else
                send_beat(r < 14 ? vcee_pkg::MODE_SET : vcee_pkg::MODE_CLEAR,
                          $urandom_range(0, w - 1), $urandom_range(0, h - 1),
                          $urandom_range(0, d - 1), $urandom_range(0, 131071));
        end
        idle_input();
    endtask

    initial
    begin
        sb = new();
        burst_left = 0;
        rst_n = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        in_valid = 1'b0;
        mode = vcee_pkg::MODE_KSPAT;
        pos_x = '0;
        pos_y = '0;
        pos_z = '0;
        kernel_value = '0;
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Fill the kernel entries that grids of up to six by six reach.
        set_grid(1, 1, 1);
        for (int y = 0; y < 6; y++)
            for (int x = 0; x < 6; x++)
                send_beat(vcee_pkg::MODE_KSPAT, x, y, 0, (x == 0 && y == 0) ? 65536 :
                          ((x == 5 && y == 5) ? 131071 : $urandom_range(0, 65536)));
        for (int z = 0; z < 4; z++)
            send_beat(vcee_pkg::MODE_KTEMP, 0, 0, z, z == 3 ? 0 : $urandom_range(0, 131071));
        idle_input();

        // Corners, a repeated set and a beat outside the single slice.
        set_grid(6, 6, 1);
        send_beat(vcee_pkg::MODE_SET, 0, 0, 0, 0);
        send_beat(vcee_pkg::MODE_SET, 5, 5, 0, 131071);
        send_beat(vcee_pkg::MODE_SET, 5, 5, 0, 0);
        send_beat(vcee_pkg::MODE_CLEAR, 0, 0, 0, 0);
        send_beat(vcee_pkg::MODE_SET, 5, 5, 3, 0);
        idle_input();

        // Whole grid set leaves no void, then double clear goes negative.
        set_grid(2, 2, 1);
        send_beat(vcee_pkg::MODE_SET, 0, 0, 0, 0);
        send_beat(vcee_pkg::MODE_SET, 1, 0, 0, 0);
        send_beat(vcee_pkg::MODE_SET, 0, 1, 0, 0);
        send_beat(vcee_pkg::MODE_SET, 1, 1, 0, 0);
        send_beat(vcee_pkg::MODE_CLEAR, 1, 1, 0, 0);
        send_beat(vcee_pkg::MODE_CLEAR, 1, 1, 0, 0);
        send_beat(vcee_pkg::MODE_SET, 2, 0, 0, 0);
        idle_input();

        // Zero acts as one, an oversized depth saturates.
        set_grid(0, 5, 7);
        send_beat(vcee_pkg::MODE_SET, 0, 4, 3, 0);
        send_beat(vcee_pkg::MODE_CLEAR, 0, 2, 1, 0);
        send_beat(vcee_pkg::MODE_SET, 1, 0, 0, 0);
        idle_input();

        set_grid(6, 6, 4);
        send_beat(vcee_pkg::MODE_SET, 5, 0, 3, 0);
        send_beat(vcee_pkg::MODE_KTEMP, 0, 0, 3, 131071);
        send_beat(vcee_pkg::MODE_CLEAR, 0, 5, 0, 0);
        idle_input();

        for (int p = 0; p < 3; p++)
            random_phase(14);

        drain();
        repeat (100) @(posedge clk);
        if (sb.mismatches == 0 && sb.expected_q.size() == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end
endmodule
